// File: hw/rtl/paxos_proposer_fsm_top_assert.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the proposer modules
// ---------------------------------------------------------------------------
`ifndef PAXOS_PROPOSER_FSM_TOP_ASSERT_SVH
`define PAXOS_PROPOSER_FSM_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PPFSM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PPFSM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ppfsm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppfsm_pkg
// shared constants, codes and job type of the paxos proposer
// ---------------------------------------------------------------------------
package ppfsm_pkg;

	localparam int MAX_ACCEPTORS = 8;
	localparam int QUEUE_DEPTH   = 4;

	// action codes
	localparam logic [2:0] ACT_START        = 3'd0;
	localparam logic [2:0] ACT_PREP_REPLY   = 3'd1;
	localparam logic [2:0] ACT_ACC_REPLY    = 3'd2;
	localparam logic [2:0] ACT_PREP_TIMEOUT = 3'd3;
	localparam logic [2:0] ACT_ACC_TIMEOUT  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_PREPARE = 2'd0;
	localparam logic [1:0] KIND_ACCEPT  = 2'd1;
	localparam logic [1:0] KIND_TIMER   = 2'd2;
	localparam logic [1:0] KIND_STATUS  = 2'd3;

	// phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PREPARE = 2'd1;
	localparam logic [1:0] PH_ACCEPT  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_OWN_ID        = 2'd0;
	localparam logic [1:0] REG_INITIAL_VALUE = 2'd1;
	localparam logic [1:0] REG_ACC_COUNT     = 2'd2;

	// work handed from front to back for one input item
	typedef struct packed {
		logic        has_round;
		logic        req_accept;
		logic [7:0]  sel;
		logic [30:0] num;
		logic [31:0] value;
		logic [1:0]  phase;
	} job_t;

	// acceptor count clamped to 1..MAX_ACCEPTORS
	function automatic logic [3:0] eff_count(logic [3:0] c);
		logic [3:0] r;
		r = c;
		if (c == 4'd0) r = 4'd1;
		else if (int'(c) > MAX_ACCEPTORS) r = 4'(MAX_ACCEPTORS);
		return r;
	endfunction

endpackage

// File: hw/rtl/ppfsm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppfsm_front
// config registers, proposer state and classification of each event
// ---------------------------------------------------------------------------
module ppfsm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                accept,
	input  logic [151:0]        evt_data,
	input  logic [2:0]          evt_action,
	output ppfsm_pkg::job_t     job
);

	logic [7:0]  own_id_q;
	logic [3:0]  acc_count_q;
	logic [1:0]  phase_q;
	logic [30:0] cur_prop_q;
	logic [31:0] cur_val_q;
	logic [7:0]  replied_q;
	logic [3:0]  ok_q;
	logic [3:0]  err_q;
	logic [31:0] hi_num_q;
	logic [31:0] hi_val_q;

	logic [7:0]  sender;
	logic [30:0] evnum;
	logic [2:0]  from_acc;
	logic        err_flag;
	logic [31:0] acc_num;
	logic [31:0] acc_val;
	logic [30:0] fresh;
	logic [7:0]  sel_in;

	logic [3:0]  eff;
	logic [3:0]  quorum;
	logic [15:0] cnt_mask;
	logic [7:0]  bit_oh;
	logic        sender_ok;
	logic        num_match;
	logic        reply_take;
	logic [3:0]  ok_inc;
	logic [3:0]  err_inc;
	logic        go_prep;
	logic        go_acc;
	logic        go_idle;

	logic [1:0]  phase_n;
	logic [30:0] cur_prop_n;
	logic [31:0] cur_val_n;
	logic [7:0]  replied_n;
	logic [3:0]  ok_n;
	logic [3:0]  err_n;
	logic [31:0] hi_num_n;
	logic [31:0] hi_val_n;

	assign sender   = evt_data[7:0];
	assign evnum    = evt_data[38:8];
	assign from_acc = evt_data[41:39];
	assign err_flag = evt_data[42];
	assign acc_num  = evt_data[74:43];
	assign acc_val  = evt_data[106:75];
	assign fresh    = evt_data[137:107];
	assign sel_in   = evt_data[145:138];

	assign eff       = ppfsm_pkg::eff_count(acc_count_q);
	assign quorum    = (eff >> 1) + 4'd1;
	assign cnt_mask  = (16'd1 << eff) - 16'd1;
	assign bit_oh    = 8'd1 << from_acc;
	assign sender_ok = (sender == own_id_q);
	assign num_match = (evnum == cur_prop_q);
	assign ok_inc    = ok_q + 4'd1;
	assign err_inc   = err_q + 4'd1;

	assign reply_take = ((evt_action == ppfsm_pkg::ACT_PREP_REPLY) ||
		(evt_action == ppfsm_pkg::ACT_ACC_REPLY)) && sender_ok && num_match &&
		(phase_q == evt_action[1:0]) && ({1'b0, from_acc} < eff) &&
		((replied_q & bit_oh) == 8'd0);

	assign go_prep =
		((evt_action == ppfsm_pkg::ACT_START) && sender_ok &&
			(phase_q == ppfsm_pkg::PH_IDLE)) ||
		(reply_take && err_flag && (err_inc == quorum)) ||
		(num_match && (((evt_action == ppfsm_pkg::ACT_PREP_TIMEOUT) &&
			(phase_q == ppfsm_pkg::PH_PREPARE)) ||
			((evt_action == ppfsm_pkg::ACT_ACC_TIMEOUT) &&
			(phase_q == ppfsm_pkg::PH_ACCEPT))));
	assign go_acc  = reply_take && !err_flag && (ok_inc == quorum) &&
		(evt_action == ppfsm_pkg::ACT_PREP_REPLY);
	assign go_idle = reply_take && !err_flag && (ok_inc == quorum) &&
		(evt_action == ppfsm_pkg::ACT_ACC_REPLY);

	always_comb begin
		phase_n    = phase_q;
		cur_prop_n = cur_prop_q;
		cur_val_n  = cur_val_q;
		replied_n  = replied_q;
		ok_n       = ok_q;
		err_n      = err_q;
		hi_num_n   = hi_num_q;
		hi_val_n   = hi_val_q;
		if (reply_take) begin
			replied_n = replied_q | bit_oh;
			if (err_flag) begin
				err_n = err_inc;
			end else begin
				ok_n = ok_inc;
				// remember the highest earlier accepted proposal
				if ((evt_action == ppfsm_pkg::ACT_PREP_REPLY) && (acc_num != '1) &&
					($signed(acc_num) > $signed(hi_num_q))) begin
					hi_num_n = acc_num;
					hi_val_n = acc_val;
				end
			end
		end
		if (go_prep) begin
			ok_n       = '0;
			err_n      = '0;
			replied_n  = '0;
			hi_num_n   = '1;
			hi_val_n   = '1;
			cur_prop_n = fresh;
			phase_n    = ppfsm_pkg::PH_PREPARE;
		end
		if (go_acc) begin
			ok_n      = '0;
			err_n     = '0;
			replied_n = '0;
			if (hi_num_n != '1) cur_val_n = hi_val_n;
			phase_n   = ppfsm_pkg::PH_ACCEPT;
		end
		if (go_idle) phase_n = ppfsm_pkg::PH_IDLE;
	end

	always_comb begin
		job.has_round  = go_prep || go_acc;
		job.req_accept = go_acc;
		job.sel        = sel_in & cnt_mask[7:0];
		job.num        = cur_prop_n;
		job.value      = cur_val_n;
		job.phase      = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= '0;
			acc_count_q <= 4'd3;
			phase_q     <= ppfsm_pkg::PH_IDLE;
			cur_prop_q  <= '0;
			cur_val_q   <= '0;
			replied_q   <= '0;
			ok_q        <= '0;
			err_q       <= '0;
			hi_num_q    <= '1;
			hi_val_q    <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				ppfsm_pkg::REG_OWN_ID:        own_id_q    <= cfg_wdata[7:0];
				ppfsm_pkg::REG_INITIAL_VALUE: cur_val_q   <= cfg_wdata;
				ppfsm_pkg::REG_ACC_COUNT:     acc_count_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end else if (accept) begin
			phase_q    <= phase_n;
			cur_prop_q <= cur_prop_n;
			cur_val_q  <= cur_val_n;
			replied_q  <= replied_n;
			ok_q       <= ok_n;
			err_q      <= err_n;
			hi_num_q   <= hi_num_n;
			hi_val_q   <= hi_val_n;
		end
	end

endmodule

// File: hw/rtl/ppfsm_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppfsm_queue
// short job queue between front and back
// ---------------------------------------------------------------------------
module ppfsm_queue #(
	parameter int DEPTH = ppfsm_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ppfsm_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output ppfsm_pkg::job_t head
);

	`include "paxos_proposer_fsm_top_assert.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ppfsm_pkg::job_t mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PW'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				if (rd_ptr_q == PW'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`PPFSM_ASSERT_IMP(a_no_overflow, push, count_q < CW'(DEPTH), "push into full queue")
	`PPFSM_ASSERT_IMP(a_no_underflow, pop, count_q != '0, "pop from empty queue")
	`PPFSM_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count lost")

endmodule

// File: hw/rtl/ppfsm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppfsm_back
// expands one job into requests and timer item if it opens a round, then a status item
// ---------------------------------------------------------------------------
module ppfsm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  ppfsm_pkg::job_t job,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [71:0]     m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);

	`include "paxos_proposer_fsm_top_assert.svh"

	typedef enum logic [2:0] {
		ST_REQ    = 3'b001,
		ST_TIMER  = 3'b010,
		ST_STATUS = 3'b100
	} bstate_t;

	bstate_t         st_q;
	logic            busy_q;
	ppfsm_pkg::job_t job_q;
	logic [7:0]      rem_q;

	logic            m_tvalid_q;
	logic [1:0]      m_kind_q;
	logic [2:0]      m_to_q;
	logic [30:0]     m_num_q;
	logic [31:0]     m_val_q;
	logic [1:0]      m_phase_q;
	logic            m_tlast_q;

	logic            adv;
	logic            finishing;
	logic [7:0]      low_bit;
	logic [7:0]      rem_after;
	logic [2:0]      low_idx;
	logic [1:0]      it_kind;
	logic [2:0]      it_to;
	logic [31:0]     it_val;
	logic            it_last;
	bstate_t         load_st;

	assign adv       = !m_tvalid_q || m_tready;
	assign finishing = busy_q && adv && (st_q == ST_STATUS);
	assign pop       = job_valid && (!busy_q || finishing);
	assign low_bit   = rem_q & (~rem_q + 8'd1);
	assign rem_after = rem_q & ~low_bit;

	always_comb begin
		low_idx = '0;
		for (int i = 7; i >= 0; i--) begin
			if (rem_q[i]) low_idx = 3'(i);
		end
	end

	always_comb begin
		it_kind = ppfsm_pkg::KIND_STATUS;
		it_to   = '0;
		it_val  = job_q.value;
		it_last = 1'b0;
		case (st_q)
			ST_REQ: begin
				it_kind = job_q.req_accept ? ppfsm_pkg::KIND_ACCEPT : ppfsm_pkg::KIND_PREPARE;
				it_to   = low_idx;
				it_val  = job_q.req_accept ? job_q.value : 32'd0;
			end
			ST_TIMER: begin
				it_kind = ppfsm_pkg::KIND_TIMER;
				it_val  = 32'd0;
			end
			ST_STATUS: begin
				it_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (!job.has_round) load_st = ST_STATUS;
		else if (job.sel != 8'd0) load_st = ST_REQ;
		else load_st = ST_TIMER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_STATUS;
			busy_q     <= 1'b0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) m_tvalid_q <= busy_q;
			if (pop) begin
				busy_q <= 1'b1;
				rem_q  <= job.sel;
				st_q   <= load_st;
			end else if (finishing) begin
				busy_q <= 1'b0;
			end else if (busy_q && adv) begin
				case (st_q)
					ST_REQ: begin
						rem_q <= rem_after;
						if (rem_after == 8'd0) st_q <= ST_TIMER;
					end
					ST_TIMER: st_q <= ST_STATUS;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= job;
		if (adv && busy_q) begin
			m_kind_q  <= it_kind;
			m_to_q    <= it_to;
			m_num_q   <= job_q.num;
			m_val_q   <= it_val;
			m_phase_q <= job_q.phase;
			m_tlast_q <= it_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {4'd0, m_phase_q, m_val_q, m_num_q, m_to_q};

	`PPFSM_ASSERT_IMP(a_state_onehot, busy_q, $onehot(st_q), "sequencer state not one-hot")
	`PPFSM_ASSERT_IMP(a_req_target, busy_q && (st_q == ST_REQ), rem_q != 8'd0, "request with no target")
	`PPFSM_ASSERT_IMP(a_last_status, m_tvalid_q, m_tlast_q == (m_kind_q == ppfsm_pkg::KIND_STATUS), "last mark off status")

endmodule

// File: hw/rtl/paxos_proposer_fsm_top.sv
`timescale 1ns / 1ps
// an item's first result reaches the output register via the job queue and the job register
// throughput: an item that starts a round gives k requests + timer + status, one per cycle,
//   unless m_tready stalls (k = selected acceptors below the count); any other item gives
//   a status item only; the single output register of the back sequencer sets that rate; a
//   4-entry job queue lets the front keep taking events meanwhile
// reset: arst_n clears state and queue, acceptor_count to 3, current value to 0
// ---------------------------------------------------------------------------
// paxos_proposer_fsm_top
// single-decree paxos proposer: event classifier, job queue, result sequencer
// ---------------------------------------------------------------------------
module paxos_proposer_fsm_top #(
	parameter int QUEUE_DEPTH = ppfsm_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// config write port: 0 own_id, 1 initial_value, 2 acceptor_count
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	// event stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// sender_proposer_id, event_proposal_number, from_acceptor, error_flag,
	// accepted_number, accepted_value, fresh_proposal_number, selected_acceptors
	input  logic [151:0] s_tdata,
	// action
	input  logic [2:0]   s_tuser,
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// to_acceptor, out_proposal_number, out_value, phase
	output logic [71:0]  m_tdata,
	// kind
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	ppfsm_pkg::job_t new_job;
	ppfsm_pkg::job_t head_job;
	logic            q_full;
	logic            q_nonempty;
	logic            q_pop;
	logic            accept;

	// the front takes an event whenever the queue has room
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// front: holds all proposer state, decides the round to start per event
	ppfsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.evt_data   (s_tdata),
		.evt_action (s_tuser),
		.job        (new_job)
	);

	// queue decouples event intake from result output
	ppfsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (new_job),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (head_job)
	);

	// back: walks the selected acceptors in ascending order, then timer, then status
	ppfsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_nonempty),
		.job       (head_job),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: dv/paxos_proposer_fsm_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// paxos_proposer_fsm_top_tb
// drives proposer events over the slave stream, predicts every request,
// timer and status item in the testbench, and checks the master stream in order
// ---------------------------------------------------------------------------
module paxos_proposer_fsm_top_tb;

	// reserved action codes: the block only answers them with a status item
	localparam logic [2:0]  ACT_RESERVED_LO = 3'd5;
	localparam logic [2:0]  ACT_RESERVED_HI = 3'd7;
	// marker for "no earlier accepted proposal"
	localparam logic [31:0] NO_PROPOSAL     = 32'hFFFF_FFFF;
	localparam int          PHASES          = 8;
	localparam int          GOOD_PER_PHASE  = 46;

	// one event on the slave stream
	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  sender;
		logic [30:0] evnum;
		logic [2:0]  src;
		logic        err;
		logic [31:0] accnum;
		logic [31:0] accval;
		logic [30:0] fresh;
		logic [7:0]  sel;
	} event_t;

	// one item on the master stream
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  to;
		logic [30:0] num;
		logic [31:0] value;
		logic [1:0]  phase;
		logic        last;
	} result_t;

	// proposer state together with its configuration registers
	typedef struct packed {
		logic [7:0]  own;
		logic [31:0] init_val;
		logic [3:0]  count;
		logic [1:0]  phase;
		logic [30:0] prop;
		logic [31:0] value;
		logic [7:0]  replied;
		logic [3:0]  oks;
		logic [3:0]  errs;
		logic [31:0] best_num;
		logic [31:0] best_val;
	} proposer_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [151:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	// tracked follows accepted items, planned follows queued items so that
	// the stimulus can aim replies and timeouts at the live proposal
	proposer_t tracked;
	proposer_t planned;
	event_t    event_q[$];
	result_t   due_msgs[$];
	event_t    on_bus;
	bit        s_taken = 1'b0;
	int        queued_cnt = 0;
	int        taken_cnt = 0;
	int        faults = 0;
	int        s_gap = 0;
	int        m_stall = 0;
	bit        idle_tx = 1'b0;
	bit        idle_rx = 1'b0;

	paxos_proposer_fsm_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// acceptor count as the block uses it: 0 acts as 1, large values clamp
	function automatic logic [3:0] live_acceptors(logic [3:0] c);
		if (c == 4'd0) return 4'd1;
		if (c > 4'(ppfsm_pkg::MAX_ACCEPTORS)) return 4'(ppfsm_pkg::MAX_ACCEPTORS);
		return c;
	endfunction

	task automatic reset_state(output proposer_t st);
		st.own      = 8'd0;
		st.init_val = 32'd0;
		st.count    = 4'd3;
		st.phase    = ppfsm_pkg::PH_IDLE;
		st.prop     = 31'd0;
		st.value    = 32'd0;
		st.replied  = 8'd0;
		st.oks      = 4'd0;
		st.errs     = 4'd0;
		st.best_num = NO_PROPOSAL;
		st.best_val = NO_PROPOSAL;
	endtask

	task automatic apply_reg(inout proposer_t st, input logic [1:0] idx,
			input logic [31:0] data);
		case (idx)
			ppfsm_pkg::REG_OWN_ID: begin
				st.own = data[7:0];
			end
			ppfsm_pkg::REG_INITIAL_VALUE: begin
				// also reloads the live value at once
				st.init_val = data;
				st.value    = data;
			end
			ppfsm_pkg::REG_ACC_COUNT: begin
				st.count = data[3:0];
			end
			default: begin
			end
		endcase
	endtask

	// every item carries the phase as it stands once the event is applied
	task automatic emit(input proposer_t st, input logic [1:0] kind, input logic [2:0] to,
			input logic [31:0] value, input logic last, input bit keep);
		result_t r;
		r.kind  = kind;
		r.to    = to;
		r.num   = st.prop;
		r.value = value;
		r.phase = st.phase;
		r.last  = last;
		if (keep) due_msgs.push_back(r);
	endtask

	// requests to the selected acceptors in ascending order, then the timer
	task automatic open_round(input proposer_t st, input logic [1:0] kind,
			input logic [7:0] sel, input bit keep);
		logic [3:0] cnt;
		cnt = live_acceptors(st.count);
		for (int i = 0; i < ppfsm_pkg::MAX_ACCEPTORS; i++) begin
			if (i < int'(cnt) && sel[i])
				emit(st, kind, 3'(i), (kind == ppfsm_pkg::KIND_ACCEPT) ? st.value : 32'd0,
					1'b0, keep);
		end
		emit(st, ppfsm_pkg::KIND_TIMER, 3'd0, 32'd0, 1'b0, keep);
	endtask

	task automatic begin_prepare(inout proposer_t st, input logic [30:0] fresh,
			input logic [7:0] sel, input bit keep);
		st.oks      = 4'd0;
		st.errs     = 4'd0;
		st.replied  = 8'd0;
		st.best_num = NO_PROPOSAL;
		st.best_val = NO_PROPOSAL;
		st.prop     = fresh;
		st.phase    = ppfsm_pkg::PH_PREPARE;
		open_round(st, ppfsm_pkg::KIND_PREPARE, sel, keep);
	endtask

	task automatic step_proposer(inout proposer_t st, input event_t ev, input bit keep);
		logic [3:0] cnt;
		logic [3:0] quorum;
		logic [7:0] bit_m;
		logic [1:0] want;
		cnt    = live_acceptors(st.count);
		quorum = cnt / 4'd2 + 4'd1;
		bit_m  = 8'd1 << ev.src;
		want   = (ev.action == ppfsm_pkg::ACT_PREP_REPLY) ? ppfsm_pkg::PH_PREPARE
			: ppfsm_pkg::PH_ACCEPT;
		case (ev.action)
			ppfsm_pkg::ACT_START: begin
				if (ev.sender == st.own && st.phase == ppfsm_pkg::PH_IDLE)
					begin_prepare(st, ev.fresh, ev.sel, keep);
			end
			ppfsm_pkg::ACT_PREP_REPLY, ppfsm_pkg::ACT_ACC_REPLY: begin
				// one reply per acceptor per phase, only for the live proposal
				if (ev.sender == st.own && ev.evnum == st.prop && st.phase == want &&
						{1'b0, ev.src} < cnt && (st.replied & bit_m) == 8'd0) begin
					st.replied = st.replied | bit_m;
					if (!ev.err) begin
						st.oks = st.oks + 4'd1;
						if (want == ppfsm_pkg::PH_PREPARE && ev.accnum != NO_PROPOSAL &&
								$signed(ev.accnum) > $signed(st.best_num)) begin
							st.best_num = ev.accnum;
							st.best_val = ev.accval;
						end
						if (st.oks == quorum) begin
							if (want == ppfsm_pkg::PH_PREPARE) begin
								// adopt the highest earlier value, if one was reported
								st.oks     = 4'd0;
								st.errs    = 4'd0;
								st.replied = 8'd0;
								if (st.best_num != NO_PROPOSAL) st.value = st.best_val;
								st.phase = ppfsm_pkg::PH_ACCEPT;
								open_round(st, ppfsm_pkg::KIND_ACCEPT, ev.sel, keep);
							end else begin
								st.phase = ppfsm_pkg::PH_IDLE;
							end
						end
					end else begin
						st.errs = st.errs + 4'd1;
						if (st.errs == quorum) begin_prepare(st, ev.fresh, ev.sel, keep);
					end
				end
			end
			ppfsm_pkg::ACT_PREP_TIMEOUT: begin
				// sender is not checked on timeouts
				if (ev.evnum == st.prop && st.phase == ppfsm_pkg::PH_PREPARE)
					begin_prepare(st, ev.fresh, ev.sel, keep);
			end
			ppfsm_pkg::ACT_ACC_TIMEOUT: begin
				if (ev.evnum == st.prop && st.phase == ppfsm_pkg::PH_ACCEPT)
					begin_prepare(st, ev.fresh, ev.sel, keep);
			end
			default: begin
			end
		endcase
		emit(st, ppfsm_pkg::KIND_STATUS, 3'd0, st.value, 1'b1, keep);
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic event_t ev_of(logic [2:0] action, logic [7:0] sender,
			logic [30:0] evnum, logic [2:0] src, logic err, logic [31:0] accnum,
			logic [31:0] accval, logic [30:0] fresh, logic [7:0] sel);
		event_t ev;
		ev.action = action;
		ev.sender = sender;
		ev.evnum  = evnum;
		ev.src    = src;
		ev.err    = err;
		ev.accnum = accnum;
		ev.accval = accval;
		ev.fresh  = fresh;
		ev.sel    = sel;
		return ev;
	endfunction

	task automatic queue_event(input event_t ev);
		step_proposer(planned, ev, 1'b0);
		event_q.push_back(ev);
		queued_cnt++;
	endtask

	// mostly events that the proposer acts on in its current phase, some near
	// misses and some plain noise; good tells whether the event was aimed
	task automatic plan_random(output bit good);
		event_t     ev;
		logic [3:0] cnt;
		logic [7:0] below;
		int         roll;
		cnt   = live_acceptors(planned.count);
		below = 8'((16'd1 << cnt) - 16'd1);
		roll  = $urandom_range(0, 99);
		ev = ev_of(3'($urandom), 8'($urandom), 31'($urandom), 3'($urandom), 1'($urandom),
			32'($urandom), 32'($urandom), 31'($urandom), 8'($urandom));
		good = 1'b0;
		if (roll < 80) begin
			good      = 1'b1;
			ev.sender = planned.own;
			ev.evnum  = planned.prop;
			ev.src    = 3'($urandom_range(0, int'(cnt) - 1));
			ev.err    = ($urandom_range(0, 3) == 0);
			ev.sel    = ($urandom_range(0, 7) == 0) ? 8'($urandom) : (8'($urandom) & below);
			if ($urandom_range(0, 15) == 0)
				ev.fresh = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
			case ($urandom_range(0, 5))
				0, 1: ev.accnum = NO_PROPOSAL;
				2: ev.accnum = 32'($urandom);
				default: ev.accnum = 32'($urandom_range(0, 200));
			endcase
			case (planned.phase)
				ppfsm_pkg::PH_IDLE: ev.action = ppfsm_pkg::ACT_START;
				ppfsm_pkg::PH_PREPARE: ev.action = ($urandom_range(0, 9) == 0)
					? ppfsm_pkg::ACT_PREP_TIMEOUT : ppfsm_pkg::ACT_PREP_REPLY;
				default: ev.action = ($urandom_range(0, 9) == 0)
					? ppfsm_pkg::ACT_ACC_TIMEOUT : ppfsm_pkg::ACT_ACC_REPLY;
			endcase
		end else if (roll < 90) begin
			// almost right: a known action with some fields matching the live round
			ev.action = 3'($urandom_range(0, 4));
			if ($urandom_range(0, 1)) ev.sender = planned.own;
			if ($urandom_range(0, 1)) ev.evnum = planned.prop;
		end
		queue_event(ev);
	endtask

	// register write on an idle block, mirrored into both proposer copies
	task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		apply_reg(tracked, idx, data);
		apply_reg(planned, idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// hold off until every queued item is taken and every result has come back
	task automatic drain;
		while (taken_cnt != queued_cnt || due_msgs.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// event driver: changes on the falling edge, random gap bursts
	// ------------------------------------------------------------------
	always @(negedge clk) begin : feed
		event_t ev;
		logic   nv;
		if (arst_n && (!s_tvalid || s_taken)) begin
			s_taken = 1'b0;
			nv = 1'b0;
			ev = on_bus;
			if (s_gap != 0) begin
				s_gap--;
			end else if (event_q.size() != 0) begin
				ev = event_q.pop_front();
				nv = 1'b1;
				if (idle_tx && $urandom_range(0, 4) == 0) s_gap = $urandom_range(1, 16);
			end
			on_bus = ev;
			s_tvalid <= nv;
			// tdata fields from bit 0: sender, event number, acceptor, error,
			// accepted number, accepted value, fresh number, selection, zero pad
			s_tdata <= {6'd0, ev.sel, ev.fresh, ev.accval, ev.accnum, ev.err, ev.src,
				ev.evnum, ev.sender};
			s_tuser <= ev.action;
		end
	end

	// result sink: stalls in random bursts
	always @(negedge clk) begin : sink
		logic rdy;
		if (arst_n) begin
			rdy = 1'b1;
			if (m_stall != 0) begin
				m_stall--;
				rdy = 1'b0;
			end else if (idle_rx && $urandom_range(0, 6) == 0) begin
				m_stall = $urandom_range(1, 16);
			end
			m_tready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// rising edge: predict on each accepted event, check each result item
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		result_t got;
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				step_proposer(tracked, on_bus, 1'b1);
				taken_cnt++;
				s_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.kind  = m_tuser;
				got.to    = m_tdata[2:0];
				got.num   = m_tdata[33:3];
				got.value = m_tdata[65:34];
				got.phase = m_tdata[67:66];
				got.last  = m_tlast;
				if (due_msgs.size() == 0) begin
					faults++;
					$display(
						"%0t: unexpected item kind=%0d to=%0d num=%h value=%h phase=%0d last=%0b",
						$time, got.kind, got.to, got.num, got.value, got.phase, got.last);
				end else begin
					want = due_msgs.pop_front();
					if (got !== want) begin
						faults++;
						$display(
							"%0t: item mismatch expected kind=%0d to=%0d num=%h value=%h %s",
							$time, want.kind, want.to, want.num, want.value,
							$sformatf("phase=%0d last=%0b", want.phase, want.last));
						$display(
							"%0t:               actual kind=%0d to=%0d num=%h value=%h %s",
							$time, got.kind, got.to, got.num, got.value,
							$sformatf("phase=%0d last=%0b", got.phase, got.last));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence: reset, directed events, then random phases under several
	// register settings, draining between them
	// ------------------------------------------------------------------
	initial begin : run
		bit good;
		int n;
		reset_state(tracked);
		reset_state(planned);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					// reset values: own id 0, initial value 0, three acceptors
					idle_tx = 1'b1;
					idle_rx = 1'b1;
				end
				1: begin
					idle_tx = 1'b1;
					idle_rx = 1'b0;
					set_reg(ppfsm_pkg::REG_OWN_ID, 32'h0000_00A5);
					set_reg(ppfsm_pkg::REG_INITIAL_VALUE, 32'h7FFF_FFFF);
					set_reg(ppfsm_pkg::REG_ACC_COUNT, 32'd8);
				end
				2: begin
					// single acceptor: quorum of one
					idle_tx = 1'b0;
					idle_rx = 1'b1;
					set_reg(ppfsm_pkg::REG_OWN_ID, 32'h0000_00FF);
					set_reg(ppfsm_pkg::REG_INITIAL_VALUE, 32'h8000_0000);
					set_reg(ppfsm_pkg::REG_ACC_COUNT, 32'd1);
				end
				3: begin
					// count 0 acts as 1; upper data bits are don't care
					idle_tx = 1'b0;
					idle_rx = 1'b0;
					set_reg(ppfsm_pkg::REG_OWN_ID, {24'($urandom), 8'h00});
					set_reg(ppfsm_pkg::REG_INITIAL_VALUE, 32'($urandom));
					set_reg(ppfsm_pkg::REG_ACC_COUNT, {28'($urandom), 4'd0});
				end
				4: begin
					// count above the maximum clamps to eight
					idle_tx = 1'b1;
					idle_rx = 1'b1;
					set_reg(ppfsm_pkg::REG_OWN_ID, 32'($urandom_range(0, 255)));
					set_reg(ppfsm_pkg::REG_INITIAL_VALUE, 32'hFFFF_FFFF);
					set_reg(ppfsm_pkg::REG_ACC_COUNT, 32'd15);
				end
				5: begin
					set_reg(ppfsm_pkg::REG_OWN_ID, 32'($urandom_range(0, 255)));
					set_reg(ppfsm_pkg::REG_INITIAL_VALUE, 32'($urandom));
					set_reg(ppfsm_pkg::REG_ACC_COUNT, 32'd5);
				end
				6: begin
					set_reg(ppfsm_pkg::REG_ACC_COUNT, 32'd2);
					set_reg(ppfsm_pkg::REG_INITIAL_VALUE, 32'($urandom));
					set_reg(ppfsm_pkg::REG_OWN_ID, 32'($urandom_range(0, 255)));
				end
				default: begin
					// closing stretch runs at full rate on both sides
					idle_tx = 1'b0;
					idle_rx = 1'b0;
					set_reg(ppfsm_pkg::REG_OWN_ID, 32'($urandom_range(0, 255)));
					set_reg(ppfsm_pkg::REG_INITIAL_VALUE, 32'($urandom));
					set_reg(ppfsm_pkg::REG_ACC_COUNT, 32'($urandom_range(1, 8)));
				end
			endcase

			if (ph == 0) begin
				// start from a foreign sender is ignored
				queue_event(ev_of(ppfsm_pkg::ACT_START, 8'h01, 31'd0, 3'd0, 1'b0,
					NO_PROPOSAL, 32'd0, 31'h1234, 8'h07));
				// selection bits at or above the count are dropped
				queue_event(ev_of(ppfsm_pkg::ACT_START, 8'h00, 31'd0, 3'd0, 1'b0,
					NO_PROPOSAL, 32'd0, 31'h7FFF_FFFF, 8'hFF));
				// start while a round is open is ignored
				queue_event(ev_of(ppfsm_pkg::ACT_START, 8'h00, 31'd0, 3'd0, 1'b0,
					NO_PROPOSAL, 32'd0, 31'h55, 8'h01));
				// reply from an acceptor beyond the count
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_REPLY, 8'h00, 31'h7FFF_FFFF, 3'd7,
					1'b0, 32'd5, 32'd9, 31'd0, 8'd0));
				// stale proposal number, then foreign sender
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_REPLY, 8'h00, 31'd0, 3'd0, 1'b0,
					32'd5, 32'd9, 31'd0, 8'd0));
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_REPLY, 8'hFF, 31'h7FFF_FFFF, 3'd0,
					1'b0, 32'd5, 32'd9, 31'd0, 8'd0));
				// good reply with the largest earlier proposal and the most negative value
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_REPLY, 8'h00, 31'h7FFF_FFFF, 3'd0,
					1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 8'd0));
				// same acceptor again is ignored
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_REPLY, 8'h00, 31'h7FFF_FFFF, 3'd0,
					1'b0, 32'd1, 32'd1, 31'd0, 8'd0));
				// accept reply in the prepare phase is ignored
				queue_event(ev_of(ppfsm_pkg::ACT_ACC_REPLY, 8'h00, 31'h7FFF_FFFF, 3'd1,
					1'b0, 32'd1, 32'd1, 31'd0, 8'd0));
				// quorum of ok replies: accept round to acceptors 0 and 2 with learned value
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_REPLY, 8'h00, 31'h7FFF_FFFF, 3'd1,
					1'b0, NO_PROPOSAL, 32'd3, 31'd0, 8'h05));
				// prepare timeout in the accept phase, accept timeout for another number
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_TIMEOUT, 8'h00, 31'h7FFF_FFFF, 3'd0,
					1'b0, 32'd0, 32'd0, 31'd9, 8'h07));
				queue_event(ev_of(ppfsm_pkg::ACT_ACC_TIMEOUT, 8'h00, 31'd1, 3'd0, 1'b0,
					32'd0, 32'd0, 31'd9, 8'h07));
				// quorum of rejections restarts prepare, here with an empty selection
				queue_event(ev_of(ppfsm_pkg::ACT_ACC_REPLY, 8'h00, 31'h7FFF_FFFF, 3'd2,
					1'b1, 32'd0, 32'd0, 31'd0, 8'h00));
				queue_event(ev_of(ppfsm_pkg::ACT_ACC_REPLY, 8'h00, 31'h7FFF_FFFF, 3'd0,
					1'b1, 32'd0, 32'd0, 31'd0, 8'h00));
				// matching prepare timeout from any sender restarts the round
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_TIMEOUT, 8'h77, 31'd0, 3'd0, 1'b0,
					32'd0, 32'd0, 31'd5, 8'h03));
				// reserved actions only report status
				queue_event(ev_of(ACT_RESERVED_LO, 8'h00, 31'd5, 3'd0, 1'b0, 32'($urandom),
					32'($urandom), 31'($urandom), 8'($urandom)));
				queue_event(ev_of(ACT_RESERVED_LO + 3'd1, 8'h00, 31'd5, 3'd1, 1'b1,
					32'($urandom), 32'($urandom), 31'($urandom), 8'($urandom)));
				queue_event(ev_of(ACT_RESERVED_HI, 8'h00, 31'd5, 3'd2, 1'b0, 32'($urandom),
					32'($urandom), 31'($urandom), 8'($urandom)));
				// negative earlier numbers never beat the none marker
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_REPLY, 8'h00, 31'd5, 3'd0, 1'b0,
					32'hFFFF_FFFB, 32'd11, 31'd0, 8'd0));
				queue_event(ev_of(ppfsm_pkg::ACT_PREP_REPLY, 8'h00, 31'd5, 3'd2, 1'b0,
					32'h8000_0000, 32'd12, 31'd0, 8'h07));
				// two ok accept replies close the round
				queue_event(ev_of(ppfsm_pkg::ACT_ACC_REPLY, 8'h00, 31'd5, 3'd0, 1'b0,
					32'd0, 32'd0, 31'd0, 8'd0));
				queue_event(ev_of(ppfsm_pkg::ACT_ACC_REPLY, 8'h00, 31'd5, 3'd1, 1'b0,
					32'd0, 32'd0, 31'd0, 8'd0));
				// accept timeout while idle is ignored
				queue_event(ev_of(ppfsm_pkg::ACT_ACC_TIMEOUT, 8'h00, 31'd5, 3'd0, 1'b0,
					32'd0, 32'd0, 31'd1, 8'h01));
			end

			n = 0;
			while (n < GOOD_PER_PHASE) begin
				plan_random(good);
				if (good) begin
					n++;
					// hold the sender until the block has nothing left to send
					if (ph == 2 && n == GOOD_PER_PHASE / 2) drain;
				end
			end
			drain;
		end

		if (faults == 0)
			$display("paxos_proposer_fsm_top_tb OK");
		else
			$display("paxos_proposer_fsm_top_tb NOT OK");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("paxos_proposer_fsm_top_tb NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ppfsm_pkg.sv
hw/rtl/ppfsm_front.sv
hw/rtl/ppfsm_queue.sv
hw/rtl/ppfsm_back.sv
hw/rtl/paxos_proposer_fsm_top.sv
dv/paxos_proposer_fsm_top_tb.sv
